// ----- design/segint_pkg.sv -----
// Shared widths, beat types and relation codes for the segment intersection test.
package segint_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;

    localparam logic [2:0] REL_CROSS        = 3'd0;
    localparam logic [2:0] REL_COL_OVERLAP  = 3'd1;
    localparam logic [2:0] REL_COL_DISJOINT = 3'd2;
    localparam logic [2:0] REL_PARALLEL     = 3'd3;
    localparam logic [2:0] REL_MISS         = 3'd4;
    localparam logic [2:0] REL_DEGENERATE   = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_val_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_val_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_val_t;

    typedef struct packed {
        coord_t first_start_x;
        coord_t first_start_y;
        coord_t first_end_x;
        coord_t first_end_y;
        coord_t second_start_x;
        coord_t second_start_y;
        coord_t second_end_x;
        coord_t second_end_y;
    } seg_in_t;

    typedef struct packed {
        logic       touches;
        logic [2:0] relation;
    } seg_out_t;

    typedef struct packed {
        diff_val_t rx;
        diff_val_t ry;
        diff_val_t sx;
        diff_val_t sy;
        diff_val_t dx;
        diff_val_t dy;
        diff_val_t ex;
        diff_val_t ey;
    } diff_t;

    typedef struct packed {
        prod_val_t rx_sy;
        prod_val_t ry_sx;
        prod_val_t dx_ry;
        prod_val_t dy_rx;
        prod_val_t dx_sy;
        prod_val_t dy_sx;
        prod_val_t rx_rx;
        prod_val_t ry_ry;
        prod_val_t dx_rx;
        prod_val_t dy_ry;
        prod_val_t ex_rx;
        prod_val_t ey_ry;
    } prod_t;

    typedef struct packed {
        sum_val_t rs;
        sum_val_t qpr;
        sum_val_t tn;
        sum_val_t rr;
        sum_val_t d0;
        sum_val_t d1;
    } sum_t;

endpackage

// ----- design/segint_diff.sv -----
// First pipeline stage: coordinate differences of the two segments.
module segint_diff
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  segint_pkg::seg_in_t     in_beat,
    output logic                    out_valid,
    output segint_pkg::diff_t       out_diff
);

    logic                 valid_reg;
    segint_pkg::diff_t    diff_reg;
    segint_pkg::diff_t    diff_next;

    always_comb
    begin
        diff_next.rx = segint_pkg::DIFF_WIDTH'(in_beat.first_end_x)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_x);
        diff_next.ry = segint_pkg::DIFF_WIDTH'(in_beat.first_end_y)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_y);
        diff_next.sx = segint_pkg::DIFF_WIDTH'(in_beat.second_end_x)
                     - segint_pkg::DIFF_WIDTH'(in_beat.second_start_x);
        diff_next.sy = segint_pkg::DIFF_WIDTH'(in_beat.second_end_y)
                     - segint_pkg::DIFF_WIDTH'(in_beat.second_start_y);
        diff_next.dx = segint_pkg::DIFF_WIDTH'(in_beat.second_start_x)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_x);
        diff_next.dy = segint_pkg::DIFF_WIDTH'(in_beat.second_start_y)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_y);
        diff_next.ex = segint_pkg::DIFF_WIDTH'(in_beat.second_end_x)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_x);
        diff_next.ey = segint_pkg::DIFF_WIDTH'(in_beat.second_end_y)
                     - segint_pkg::DIFF_WIDTH'(in_beat.first_start_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            diff_reg <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_diff  = diff_reg;

endmodule

// ----- design/segint_mul.sv -----
// Second pipeline stage: the twelve products behind the cross and dot products.
module segint_mul
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  segint_pkg::diff_t       in_diff,
    output logic                    out_valid,
    output segint_pkg::prod_t       out_prod
);

    logic                 valid_reg;
    segint_pkg::prod_t    prod_reg;
    segint_pkg::prod_t    prod_next;

    function automatic segint_pkg::prod_val_t smul(segint_pkg::diff_val_t a,
                                                   segint_pkg::diff_val_t b);
        segint_pkg::prod_val_t wa;
        segint_pkg::prod_val_t wb;
        wa = segint_pkg::PROD_WIDTH'(a);
        wb = segint_pkg::PROD_WIDTH'(b);
        return wa * wb;
    endfunction

    always_comb
    begin
        prod_next.rx_sy = smul(in_diff.rx, in_diff.sy);
        prod_next.ry_sx = smul(in_diff.ry, in_diff.sx);
        prod_next.dx_ry = smul(in_diff.dx, in_diff.ry);
        prod_next.dy_rx = smul(in_diff.dy, in_diff.rx);
        prod_next.dx_sy = smul(in_diff.dx, in_diff.sy);
        prod_next.dy_sx = smul(in_diff.dy, in_diff.sx);
        prod_next.rx_rx = smul(in_diff.rx, in_diff.rx);
        prod_next.ry_ry = smul(in_diff.ry, in_diff.ry);
        prod_next.dx_rx = smul(in_diff.dx, in_diff.rx);
        prod_next.dy_ry = smul(in_diff.dy, in_diff.ry);
        prod_next.ex_rx = smul(in_diff.ex, in_diff.rx);
        prod_next.ey_ry = smul(in_diff.ey, in_diff.ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

// ----- design/segint_sum.sv -----
// Third pipeline stage: cross products, squared length and projections.
module segint_sum
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  segint_pkg::prod_t       in_prod,
    output logic                    out_valid,
    output segint_pkg::sum_t        out_sum
);

    logic                 valid_reg;
    segint_pkg::sum_t     sum_reg;
    segint_pkg::sum_t     sum_next;

    always_comb
    begin
        sum_next.rs  = segint_pkg::SUM_WIDTH'(in_prod.rx_sy)
                     - segint_pkg::SUM_WIDTH'(in_prod.ry_sx);
        sum_next.qpr = segint_pkg::SUM_WIDTH'(in_prod.dx_ry)
                     - segint_pkg::SUM_WIDTH'(in_prod.dy_rx);
        sum_next.tn  = segint_pkg::SUM_WIDTH'(in_prod.dx_sy)
                     - segint_pkg::SUM_WIDTH'(in_prod.dy_sx);
        sum_next.rr  = segint_pkg::SUM_WIDTH'(in_prod.rx_rx)
                     + segint_pkg::SUM_WIDTH'(in_prod.ry_ry);
        sum_next.d0  = segint_pkg::SUM_WIDTH'(in_prod.dx_rx)
                     + segint_pkg::SUM_WIDTH'(in_prod.dy_ry);
        sum_next.d1  = segint_pkg::SUM_WIDTH'(in_prod.ex_rx)
                     + segint_pkg::SUM_WIDTH'(in_prod.ey_ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sum   = sum_reg;

endmodule

// ----- design/segint_decide.sv -----
// Fourth and fifth pipeline stages: zero tests, sign normalization and the relation code.
module segint_decide
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  segint_pkg::sum_t        in_sum,
    output logic                    out_valid,
    output segint_pkg::seg_out_t    out_result
);

    logic                     norm_valid_reg;
    logic                     rs_zero_reg;
    logic                     qpr_zero_reg;
    logic                     rr_zero_reg;
    segint_pkg::sum_val_t     rr_reg;
    segint_pkg::sum_val_t     lo_reg;
    segint_pkg::sum_val_t     hi_reg;
    segint_pkg::sum_val_t     tn_reg;
    segint_pkg::sum_val_t     un_reg;
    segint_pkg::sum_val_t     den_reg;
    segint_pkg::sum_val_t     lo_next;
    segint_pkg::sum_val_t     hi_next;
    segint_pkg::sum_val_t     tn_next;
    segint_pkg::sum_val_t     un_next;
    segint_pkg::sum_val_t     den_next;

    logic                     res_valid_reg;
    segint_pkg::seg_out_t     res_reg;
    segint_pkg::seg_out_t     res_next;
    logic                     overlap;
    logic                     cross_hit;

    always_comb
    begin
        if (in_sum.d0 < in_sum.d1)
        begin
            lo_next = in_sum.d0;
            hi_next = in_sum.d1;
        end
        else
        begin
            lo_next = in_sum.d1;
            hi_next = in_sum.d0;
        end
        if (in_sum.rs < 0)
        begin
            den_next = -in_sum.rs;
            tn_next  = -in_sum.tn;
            un_next  = -in_sum.qpr;
        end
        else
        begin
            den_next = in_sum.rs;
            tn_next  = in_sum.tn;
            un_next  = in_sum.qpr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            norm_valid_reg <= in_valid;
            res_valid_reg  <= norm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rs_zero_reg  <= (in_sum.rs == '0);
            qpr_zero_reg <= (in_sum.qpr == '0);
            rr_zero_reg  <= (in_sum.rr == '0);
            rr_reg       <= in_sum.rr;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            tn_reg       <= tn_next;
            un_reg       <= un_next;
            den_reg      <= den_next;
        end
    end

    assign overlap   = (lo_reg <= rr_reg) && (hi_reg >= 0);
    assign cross_hit = (tn_reg >= 0) && (tn_reg <= den_reg)
                    && (un_reg >= 0) && (un_reg <= den_reg);

    always_comb
    begin
        priority if (rs_zero_reg && qpr_zero_reg && rr_zero_reg)
        begin
            res_next.touches  = 1'b0;
            res_next.relation = segint_pkg::REL_DEGENERATE;
        end
        else if (rs_zero_reg && qpr_zero_reg)
        begin
            res_next.touches  = overlap;
            res_next.relation = overlap ? segint_pkg::REL_COL_OVERLAP
                                        : segint_pkg::REL_COL_DISJOINT;
        end
        else if (rs_zero_reg)
        begin
            res_next.touches  = 1'b0;
            res_next.relation = segint_pkg::REL_PARALLEL;
        end
        else
        begin
            res_next.touches  = cross_hit;
            res_next.relation = cross_hit ? segint_pkg::REL_CROSS
                                          : segint_pkg::REL_MISS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (norm_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

// ----- design/segment_intersection_test_top.sv -----
// Top level of the segment intersection test pipeline.
//
// A segment pair is one input beat on item, taken at a rising edge where
// start is high and busy is low. Busy is always low, so a new pair may be
// issued in every cycle and the block sustains one pair per clock.
// Each pair yields exactly one result beat on result, marked by done for a
// single cycle. Done rises once the pair has passed the difference, product,
// sum, normalization and result registers. Results leave in the order the
// pairs came in.
// The five register stages are coordinate differences, twelve 17 by 17
// bit products, the cross and dot product sums, zero tests with sign
// normalization, and the final compare that forms touches and relation.
// The product stage sets the depth of the critical path.
// The receiver cannot hold results off, and since every stage advances in
// every cycle nothing ever backs up inside the block.
// Reset clears the valid bits of all stages, so no result beat appears
// until a pair is issued after reset is released. Data registers are not
// reset.
module segment_intersection_test_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  segint_pkg::seg_in_t     item,
    output logic                    done,
    output segint_pkg::seg_out_t    result
);

    logic                 diff_valid;
    segint_pkg::diff_t    diff;
    logic                 prod_valid;
    segint_pkg::prod_t    prod;
    logic                 sum_valid;
    segint_pkg::sum_t     sum;

    assign busy = 1'b0;

    segint_diff u_diff
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_beat   (item),
        .out_valid (diff_valid),
        .out_diff  (diff)
    );

    segint_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .in_diff   (diff),
        .out_valid (prod_valid),
        .out_prod  (prod)
    );

    segint_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_prod   (prod),
        .out_valid (sum_valid),
        .out_sum   (sum)
    );

    segint_decide u_decide
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sum_valid),
        .in_sum     (sum),
        .out_valid  (done),
        .out_result (result)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the segment intersection test block.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 50000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_PHASE = 250;
    localparam int REPORT_LIMIT = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    segint_pkg::seg_in_t  item = '0;
    logic                 done;
    segint_pkg::seg_out_t result;

    segint_pkg::seg_in_t  pending_pairs[$];
    segint_pkg::seg_out_t awaited_results[$];
    int                   gap_percent = 32;
    int                   fail_count = 0;
    int                   result_index = 0;
    int                   cycle_count = 0;

    segment_intersection_test_top i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic segint_pkg::seg_out_t classify_pair(segint_pkg::seg_in_t p);
        longint px, py, rx, ry, qx, qy, sx, sy, dx, dy;
        longint rs, qpr, rr, d0, d1, lo, hi, tn, un, den;
        segint_pkg::seg_out_t o;
        px  = longint'($signed(p.first_start_x));
        py  = longint'($signed(p.first_start_y));
        rx  = longint'($signed(p.first_end_x)) - px;
        ry  = longint'($signed(p.first_end_y)) - py;
        qx  = longint'($signed(p.second_start_x));
        qy  = longint'($signed(p.second_start_y));
        sx  = longint'($signed(p.second_end_x)) - qx;
        sy  = longint'($signed(p.second_end_y)) - qy;
        dx  = qx - px;
        dy  = qy - py;
        rs  = rx * sy - ry * sx;
        qpr = dx * ry - dy * rx;
        if (rs == 0 && qpr == 0)
        begin
            rr = rx * rx + ry * ry;
            if (rr == 0)
            begin
                o.touches  = 1'b0;
                o.relation = segint_pkg::REL_DEGENERATE;
            end
            else
            begin
                d0 = dx * rx + dy * ry;
                d1 = (dx + sx) * rx + (dy + sy) * ry;
                lo = (d0 < d1) ? d0 : d1;
                hi = (d0 < d1) ? d1 : d0;
                o.touches  = (lo <= rr && hi >= 0);
                o.relation = o.touches ? segint_pkg::REL_COL_OVERLAP
                                       : segint_pkg::REL_COL_DISJOINT;
            end
        end
        else if (rs == 0)
        begin
            o.touches  = 1'b0;
            o.relation = segint_pkg::REL_PARALLEL;
        end
        else
        begin
            tn  = dx * sy - dy * sx;
            un  = qpr;
            den = rs;
            if (den < 0)
            begin
                den = -den;
                tn  = -tn;
                un  = -un;
            end
            o.touches  = (tn >= 0 && tn <= den && un >= 0 && un <= den);
            o.relation = o.touches ? segint_pkg::REL_CROSS : segint_pkg::REL_MISS;
        end
        return o;
    endfunction

    function automatic segint_pkg::seg_in_t make_pair(int ax, int ay, int bx, int by,
                                                      int cx, int cy, int ex, int ey);
        segint_pkg::seg_in_t p;
        p.first_start_x  = segint_pkg::coord_t'(ax);
        p.first_start_y  = segint_pkg::coord_t'(ay);
        p.first_end_x    = segint_pkg::coord_t'(bx);
        p.first_end_y    = segint_pkg::coord_t'(by);
        p.second_start_x = segint_pkg::coord_t'(cx);
        p.second_start_y = segint_pkg::coord_t'(cy);
        p.second_end_x   = segint_pkg::coord_t'(ex);
        p.second_end_y   = segint_pkg::coord_t'(ey);
        return p;
    endfunction

    function automatic int spread(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic segint_pkg::seg_in_t random_pair();
        int cx, cy, ax, ay, bx, by, k0, k1, k2, k3, ox, oy;
        segint_pkg::seg_in_t p;
        cx = spread(10000);
        cy = spread(10000);
        ax = spread(100);
        ay = spread(100);
        bx = spread(100);
        by = spread(100);
        k0 = spread(50);
        k1 = spread(50);
        k2 = spread(50);
        k3 = spread(50);
        ox = spread(3);
        oy = spread(3);
        case ($urandom_range(9))
            0, 1: p = segint_pkg::seg_in_t'({$urandom(), $urandom(),
                                             $urandom(), $urandom()});
            2: p = make_pair(spread(6), spread(6), spread(6), spread(6),
                             spread(6), spread(6), spread(6), spread(6));
            3, 4: p = make_pair(cx - int'($urandom_range(50)) * ax,
                                cy - int'($urandom_range(50)) * ay,
                                cx + k1 * ax, cy + k1 * ay,
                                cx - int'($urandom_range(50)) * bx,
                                cy - int'($urandom_range(50)) * by,
                                cx + k3 * bx, cy + k3 * by);
            5, 6: p = make_pair(cx + k0 * ax, cy + k0 * ay, cx + k1 * ax, cy + k1 * ay,
                                cx + k2 * ax, cy + k2 * ay, cx + k3 * ax, cy + k3 * ay);
            7: p = make_pair(cx + k0 * ax, cy + k0 * ay, cx + k1 * ax, cy + k1 * ay,
                             cx + k2 * ax + ox, cy + k2 * ay + oy,
                             cx + k3 * ax + ox, cy + k3 * ay + oy);
            8:
            begin
                if ($urandom_range(1) == 0)
                    p = make_pair(cx, cy, cx, cy, cx + k2 * bx, cy + k2 * by,
                                  cx + k3 * bx, cy + k3 * by);
                else
                    p = make_pair(cx + k0 * ax, cy + k0 * ay, cx + k1 * ax, cy + k1 * ay,
                                  cx + k2 * ax + ox, cy + k2 * ay + oy,
                                  cx + k2 * ax + ox, cy + k2 * ay + oy);
            end
            default: p = make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                                   extreme_coord(), extreme_coord(), extreme_coord(),
                                   extreme_coord(), extreme_coord());
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || start || awaited_results.size() != 0);
    endtask

    task automatic wait_sent();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
                awaited_results.push_back(classify_pair(item));
            if (!start || !busy)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= gap_percent)
                begin
                    start <= 1'b1;
                    item  <= pending_pairs.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                if (fail_count < REPORT_LIMIT)
                    $display("result beat %0d arrived with nothing outstanding", result_index);
                fail_count++;
            end
            else
            begin
                segint_pkg::seg_out_t want;
                want = awaited_results.pop_front();
                if (result.touches !== want.touches || result.relation !== want.relation)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("beat %0d: expected touches %0b relation %0d, got %0b %0d",
                                 result_index, want.touches, want.relation,
                                 result.touches, result.relation);
                    fail_count++;
                end
            end
            result_index++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 0, 30, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 20, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, -5, 0, -1, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 1, 10, 11));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 4, 0, 4, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 4, 3, 4, 3));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 11, 0, 11, 0));
        pending_pairs.push_back(make_pair(10, 0, 0, 0, 5, -5, 5, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 5, 5, -5));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767,
                                          -32768, 32767, -32768, -32768));
        pending_pairs.push_back(make_pair(0, 0, 4, 2, 6, 3, 8, 4));
        pending_pairs.push_back(make_pair(0, 0, 100, 1, 0, 1, 100, 0));
        pending_pairs.push_back(make_pair(0, 0, 100, 0, 200, -1, 200, 1));
        pending_pairs.push_back(make_pair(-1, -1, 1, 1, 32767, -32768, -32768, 32767));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, -10, 0, 0, 0));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The sender holds off here until every outstanding beat has returned.
        wait_drained();
        for (int n = 0; n < RANDOM_PHASE; n++)
            pending_pairs.push_back(random_pair());
        wait_drained();
        gap_percent = 0;
        for (int n = 0; n < RANDOM_PHASE; n++)
            pending_pairs.push_back(random_pair());
        wait_sent();
        gap_percent = 32;
        for (int n = 0; n < RANDOM_PHASE; n++)
            pending_pairs.push_back(random_pair());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/segint_pkg.sv
design/segint_diff.sv
design/segint_mul.sv
design/segint_sum.sv
design/segint_decide.sv
design/segment_intersection_test_top.sv
sim/tb.sv
